/* rtl/mfap_pkg.sv */
// Shared types and constants for the MAVLink frame parser with attitude decode.
// Used by the parser, the angle converter, the result queue, the top level and the bench; no dependencies.
package mfap_pkg;

  // Start-of-frame markers
  localparam logic [7:0] START_V1 = 8'hFE;
  localparam logic [7:0] START_V2 = 8'hFD;

  // Header byte positions after the start byte
  localparam logic [7:0] HDR_LEN      = 8'd0;
  localparam logic [7:0] HDR_V1_SEQ   = 8'd1;
  localparam logic [7:0] HDR_V1_SYS   = 8'd2;
  localparam logic [7:0] HDR_V1_COMP  = 8'd3;
  localparam logic [7:0] HDR_V1_ID    = 8'd4;
  localparam logic [7:0] HDR_V2_SEQ   = 8'd3;
  localparam logic [7:0] HDR_V2_SYS   = 8'd4;
  localparam logic [7:0] HDR_V2_COMP  = 8'd5;
  localparam logic [7:0] HDR_V2_ID0   = 8'd6;
  localparam logic [7:0] HDR_V2_ID1   = 8'd7;
  localparam logic [7:0] HDR_V2_ID2   = 8'd8;
  localparam logic [7:0] HDR_LAST_V1  = 8'd4;
  localparam logic [7:0] HDR_LAST_V2  = 8'd8;

  // Number of payload bytes kept
  localparam logic [7:0] HEAD_DEPTH = 8'd16;

  // Register reset value
  localparam logic [23:0] ATT_ID_RESET = 24'd30;

  // 18000/pi in unsigned Q.27, split for two 24x20 multipliers
  localparam logic [39:0] CDEG_PER_RAD_Q27 = 40'd769010935023;
  localparam logic [19:0] CDEG_KH = CDEG_PER_RAD_Q27[39:20];
  localparam logic [19:0] CDEG_KL = CDEG_PER_RAD_Q27[19:0];

  // Exponent landmarks: shift = 177 - exp; saturate at or above 177, zero at or below 113
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [8:0] EXP_SHIFT_BASE = 9'd177;
  localparam logic [7:0] EXP_SAT_MIN = 8'd177;
  localparam logic [7:0] EXP_ZERO_MAX = 8'd113;

  // Result queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // Header fields of one finished frame
  typedef struct packed {
    logic        version;
    logic [7:0]  seq;
    logic [7:0]  sys;
    logic [7:0]  comp;
    logic [23:0] msg_id;
    logic [7:0]  len;
    logic        att_valid;
    logic [31:0] boot_ms;
  } frame_hdr_t;

  // Roll, pitch, yaw as IEEE single bits (zero when not an attitude frame)
  typedef logic [2:0][31:0] angle_words_t;

endpackage

/* rtl/mfap_parser.sv */
// Byte-level frame parser: hunts for start bytes, captures the header and
// the first payload bytes, and emits one frame record per frame. Uses mfap_pkg.
module mfap_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_vld,
  input  logic [7:0]            byte_in,
  input  logic [23:0]           att_id,
  input  logic                  accept_v1,
  input  logic                  accept_v2,
  output logic                  rec_vld_r,
  output mfap_pkg::frame_hdr_t  rec_hdr_r,
  output mfap_pkg::angle_words_t rec_ang_r
);
  import mfap_pkg::*;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic             ver_r, ver_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       seq_r, seq_nxt;
  logic [7:0]       sys_r, sys_nxt;
  logic [7:0]       comp_r, comp_nxt;
  logic [23:0]      id_r, id_nxt;
  logic [15:0][7:0] head_r, head_nxt;
  logic             rec_vld_nxt;
  frame_hdr_t       rec_hdr_nxt;
  angle_words_t     rec_ang_nxt;
  logic [7:0]       hdr_last;
  logic [31:0]      ts;
  logic             att_ok;

  // Timestamp and attitude match on the current frame
  assign ts       = {head_r[3], head_r[2], head_r[1], head_r[0]};
  assign att_ok   = (id_r == att_id) && (ts != 32'd0);
  assign hdr_last = ver_r ? HDR_LAST_V2 : HDR_LAST_V1;

  // Frame record built on the second checksum byte
  always_comb begin
    rec_hdr_nxt.version   = ver_r;
    rec_hdr_nxt.seq       = seq_r;
    rec_hdr_nxt.sys       = sys_r;
    rec_hdr_nxt.comp      = comp_r;
    rec_hdr_nxt.msg_id    = id_r;
    rec_hdr_nxt.len       = len_r;
    rec_hdr_nxt.att_valid = att_ok;
    rec_hdr_nxt.boot_ms   = att_ok ? ts : 32'd0;
    rec_ang_nxt[0] = att_ok ? {head_r[7], head_r[6], head_r[5], head_r[4]} : 32'd0;
    rec_ang_nxt[1] = att_ok ? {head_r[11], head_r[10], head_r[9], head_r[8]} : 32'd0;
    rec_ang_nxt[2] = att_ok ? {head_r[15], head_r[14], head_r[13], head_r[12]} : 32'd0;
  end

  // Next-state logic for one accepted byte
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    ver_nxt     = ver_r;
    len_nxt     = len_r;
    seq_nxt     = seq_r;
    sys_nxt     = sys_r;
    comp_nxt    = comp_r;
    id_nxt      = id_r;
    head_nxt    = head_r;
    rec_vld_nxt = 1'b0;
    if (byte_vld) begin
      case (phase_r)
        PH_HUNT: begin
          if ((byte_in == START_V2 && accept_v2) || (byte_in == START_V1 && accept_v1)) begin
            ver_nxt   = (byte_in == START_V2);
            cnt_nxt   = 8'd0;
            id_nxt    = 24'd0;
            head_nxt  = '0;
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (ver_r) begin
            if (cnt_r == HDR_LEN)          len_nxt  = byte_in;
            else if (cnt_r == HDR_V2_SEQ)  seq_nxt  = byte_in;
            else if (cnt_r == HDR_V2_SYS)  sys_nxt  = byte_in;
            else if (cnt_r == HDR_V2_COMP) comp_nxt = byte_in;
            else if (cnt_r == HDR_V2_ID0)  id_nxt[7:0]   = byte_in;
            else if (cnt_r == HDR_V2_ID1)  id_nxt[15:8]  = byte_in;
            else if (cnt_r == HDR_V2_ID2)  id_nxt[23:16] = byte_in;
          end else begin
            if (cnt_r == HDR_LEN)          len_nxt  = byte_in;
            else if (cnt_r == HDR_V1_SEQ)  seq_nxt  = byte_in;
            else if (cnt_r == HDR_V1_SYS)  sys_nxt  = byte_in;
            else if (cnt_r == HDR_V1_COMP) comp_nxt = byte_in;
            else if (cnt_r == HDR_V1_ID)   id_nxt   = {16'd0, byte_in};
          end
          if (cnt_r >= hdr_last) begin
            cnt_nxt   = 8'd0;
            phase_nxt = (len_nxt != 8'd0) ? PH_PAYLOAD : PH_CHECK;
          end else begin
            cnt_nxt = cnt_r + 8'd1;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_r < HEAD_DEPTH) head_nxt[cnt_r[3:0]] = byte_in;
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt >= len_r) begin
            cnt_nxt   = 8'd0;
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          // checksum bytes are skipped, not checked
          if (cnt_r == 8'd0) begin
            cnt_nxt = 8'd1;
          end else begin
            rec_vld_nxt = 1'b1;
            cnt_nxt     = 8'd0;
            phase_nxt   = PH_HUNT;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          cnt_nxt   = 8'd0;
        end
      endcase
    end
  end

  // Parser state and frame record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      cnt_r     <= 8'd0;
      ver_r     <= 1'b0;
      len_r     <= 8'd0;
      seq_r     <= 8'd0;
      sys_r     <= 8'd0;
      comp_r    <= 8'd0;
      id_r      <= 24'd0;
      head_r    <= '0;
      rec_vld_r <= 1'b0;
      rec_hdr_r <= '0;
      rec_ang_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      cnt_r     <= cnt_nxt;
      ver_r     <= ver_nxt;
      len_r     <= len_nxt;
      seq_r     <= seq_nxt;
      sys_r     <= sys_nxt;
      comp_r    <= comp_nxt;
      id_r      <= id_nxt;
      head_r    <= head_nxt;
      rec_vld_r <= rec_vld_nxt;
      if (rec_vld_nxt) begin
        rec_hdr_r <= rec_hdr_nxt;
        rec_ang_r <= rec_ang_nxt;
      end
    end
  end

endmodule

/* rtl/mfap_angle_cvt.sv */
// Three-stage pipeline turning IEEE single radians into signed centidegrees,
// truncated toward zero and saturated. Uses mfap_pkg.
module mfap_angle_cvt #(
  parameter int unsigned ANGLE_BITS = 24
) (
  input  logic                  clk,
  input  logic [31:0]           fbits,
  output logic [ANGLE_BITS-1:0] cdeg_r,
  output logic                  clip_r
);
  import mfap_pkg::*;

  localparam logic [ANGLE_BITS-1:0] MAXV = {1'b0, {(ANGLE_BITS - 1){1'b1}}};

  logic        sgn;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [23:0] mant;
  logic [8:0]  sh9;

  // stage A: decode and partial products
  logic        sgn_a_r, nan_a_r, inf_a_r, big_a_r, tiny_a_r;
  logic [5:0]  sh_a_r;
  logic [43:0] ph_a_r, pl_a_r;
  // stage B: full product
  logic        sgn_b_r, nan_b_r, inf_b_r, big_b_r, tiny_b_r;
  logic [5:0]  sh_b_r;
  logic [63:0] p_b_r;
  // stage C: shift, saturate, sign
  logic [63:0]           mag;
  logic                  over;
  logic [ANGLE_BITS-1:0] mag_sat;
  logic [ANGLE_BITS-1:0] cdeg_nxt;
  logic                  clip_nxt;

  assign sgn  = fbits[31];
  assign ex   = fbits[30:23];
  assign fr   = fbits[22:0];
  assign mant = (ex == 8'd0) ? {1'b0, fr} : {1'b1, fr};
  assign sh9  = EXP_SHIFT_BASE - {1'b0, ex};

  always_ff @(posedge clk) begin
    sgn_a_r  <= sgn;
    nan_a_r  <= (ex == EXP_SPECIAL) && (fr != 23'd0);
    inf_a_r  <= (ex == EXP_SPECIAL) && (fr == 23'd0);
    big_a_r  <= (ex >= EXP_SAT_MIN);
    tiny_a_r <= (ex <= EXP_ZERO_MAX);
    sh_a_r   <= sh9[5:0];
    ph_a_r   <= 44'(mant) * 44'(CDEG_KH);
    pl_a_r   <= 44'(mant) * 44'(CDEG_KL);
  end

  always_ff @(posedge clk) begin
    sgn_b_r  <= sgn_a_r;
    nan_b_r  <= nan_a_r;
    inf_b_r  <= inf_a_r;
    big_b_r  <= big_a_r;
    tiny_b_r <= tiny_a_r;
    sh_b_r   <= sh_a_r;
    p_b_r    <= {ph_a_r, 20'd0} + 64'(pl_a_r);
  end

  // Magnitude, saturation and sign
  always_comb begin
    mag      = tiny_b_r ? 64'd0 : (p_b_r >> sh_b_r);
    over     = inf_b_r || big_b_r || (|mag[63:ANGLE_BITS-1]);
    mag_sat  = over ? MAXV : mag[ANGLE_BITS-1:0];
    cdeg_nxt = sgn_b_r ? (~mag_sat + 1'b1) : mag_sat;
    clip_nxt = over;
    if (nan_b_r) begin
      cdeg_nxt = '0;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cdeg_r <= cdeg_nxt;
    clip_r <= clip_nxt;
  end

endmodule

/* rtl/mfap_out_queue.sv */
// Two-entry result queue between the conversion pipeline and the output channel.
// Uses mfap_pkg for its depth.
module mfap_out_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output logic [WIDTH-1:0] out_data,
  output logic [1:0]       cnt_r
);
  import mfap_pkg::*;

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic             wr_ptr_r, rd_ptr_r;
  logic             pop;

  assign out_vld  = (cnt_r != 2'd0);
  assign out_data = entry_r[rd_ptr_r];
  assign pop      = out_vld && out_rdy;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  // Word storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

/* rtl/mavlink_frame_attitude_parser_top.sv */
// Top level of the MAVLink frame parser with attitude decode: config registers,
// parser, three angle converters and the result queue. Uses mfap_pkg.
//
// Usage:
//   in_*  : one link byte per word (in_tdata[7:0]); a word is taken at any edge
//           with in_tvalid and in_tready high, so one byte per cycle is taken while in_tready stays high.
//   out_* : one word per MAVLink frame, given after its second checksum byte.
//           out_tuser bit 0 is the frame version, bit 1 the attitude-valid flag.
//   cfg_* : APB registers: 0x0 attitude message id (24 bit), 0x4 accept
//           version 1, 0x8 accept version 2. pready is always high.
// Result path: the edge that takes the last checksum byte loads the record register,
//   then the three converter stages and the queue lie before out_tvalid rises.
// Throughput: one byte per cycle while in_tready is high; results follow at most one per frame,
//   and a frame is at least 8 bytes long.
// Stall: a two-entry result queue holds finished words; bytes are still taken
//   while a word waits, and in_tready drops only when the queue plus words in
//   flight reach two.
// Reset: synchronous, active low; the parser returns to hunting for a start
//   byte, the queue empties and the registers take id 30 with both versions on.
module mavlink_frame_attitude_parser_top #(
  parameter int unsigned ANGLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // data_byte
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // seq_num, system_id, component_id, msg_id, payload_length, boot_time_ms,
  // roll_cdeg, pitch_cdeg, yaw_cdeg, angle_clipped, zero fill
  output logic [((89 + 3 * ANGLE_BITS + 7) / 8) * 8 - 1:0] out_tdata,
  // frame_version, attitude_valid
  output logic [1:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [3:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import mfap_pkg::*;

  localparam int unsigned PAYLOAD_W = 89 + 3 * ANGLE_BITS;
  localparam int unsigned TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
  localparam int unsigned QWORD_W   = TDATA_W + 2;

  localparam logic [1:0] REG_ATT_ID    = 2'd0;
  localparam logic [1:0] REG_ACCEPT_V1 = 2'd1;
  localparam logic [1:0] REG_ACCEPT_V2 = 2'd2;

  logic [23:0]  att_id_r;
  logic         accept_v1_r, accept_v2_r;
  logic         cfg_wr;
  logic         byte_vld;
  logic         rec_vld_r;
  frame_hdr_t   rec_hdr_r;
  angle_words_t rec_ang_r;
  logic [2:0]   cvt_vld_r;
  frame_hdr_t   hdr_d_r [3];
  logic [2:0][ANGLE_BITS-1:0] cdeg;
  logic [2:0]   clip;
  logic [1:0]   q_cnt;
  logic [2:0]   busy;
  logic [TDATA_W-1:0] tdata_nxt;
  logic [QWORD_W-1:0] qword_nxt;
  logic [QWORD_W-1:0] qword_out;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      att_id_r    <= ATT_ID_RESET;
      accept_v1_r <= 1'b1;
      accept_v2_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_ATT_ID:    att_id_r    <= cfg_pwdata[23:0];
        REG_ACCEPT_V1: accept_v1_r <= cfg_pwdata[0];
        REG_ACCEPT_V2: accept_v2_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ATT_ID:    cfg_prdata = {8'd0, att_id_r};
      REG_ACCEPT_V1: cfg_prdata = {31'd0, accept_v1_r};
      REG_ACCEPT_V2: cfg_prdata = {31'd0, accept_v2_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Input flow control: words in flight plus queued never exceed the queue
  assign busy      = 3'(q_cnt) + 3'(rec_vld_r) + 3'(cvt_vld_r[0]) + 3'(cvt_vld_r[1])
                   + 3'(cvt_vld_r[2]);
  assign in_tready = (busy < 3'(QUEUE_DEPTH));
  assign byte_vld  = in_tvalid && in_tready;

  mfap_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (byte_vld),
    .byte_in   (in_tdata),
    .att_id    (att_id_r),
    .accept_v1 (accept_v1_r),
    .accept_v2 (accept_v2_r),
    .rec_vld_r (rec_vld_r),
    .rec_hdr_r (rec_hdr_r),
    .rec_ang_r (rec_ang_r)
  );

  // One converter per angle
  for (genvar g = 0; g < 3; g++) begin : g_cvt
    mfap_angle_cvt #(.ANGLE_BITS(ANGLE_BITS)) u_cvt (
      .clk    (clk),
      .fbits  (rec_ang_r[g]),
      .cdeg_r (cdeg[g]),
      .clip_r (clip[g])
    );
  end

  // Header fields travel alongside the converter stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvt_vld_r <= 3'd0;
    end else begin
      cvt_vld_r <= {cvt_vld_r[1:0], rec_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    hdr_d_r[0] <= rec_hdr_r;
    hdr_d_r[1] <= hdr_d_r[0];
    hdr_d_r[2] <= hdr_d_r[1];
  end

  // Result word assembly
  always_comb begin
    tdata_nxt = '0;
    tdata_nxt[PAYLOAD_W-1:0] = {(|clip), cdeg[2], cdeg[1], cdeg[0],
                                hdr_d_r[2].boot_ms, hdr_d_r[2].len, hdr_d_r[2].msg_id,
                                hdr_d_r[2].comp, hdr_d_r[2].sys, hdr_d_r[2].seq};
    qword_nxt = {hdr_d_r[2].att_valid, hdr_d_r[2].version, tdata_nxt};
  end

  mfap_out_queue #(.WIDTH(QWORD_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cvt_vld_r[2]),
    .push_data (qword_nxt),
    .out_vld   (out_tvalid),
    .out_rdy   (out_tready),
    .out_data  (qword_out),
    .cnt_r     (q_cnt)
  );

  assign out_tdata = qword_out[TDATA_W-1:0];
  assign out_tuser = qword_out[QWORD_W-1:TDATA_W];

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for mavlink_frame_attitude_parser_top: drives link bytes,
// predicts each frame word and its attitude decode, and checks every result word.
// Depends on mfap_pkg and the RTL of mavlink_frame_attitude_parser_top only.
module testbench;
  import mfap_pkg::*;

  localparam int ANGLE_BITS   = 24;
  localparam int TDATA_W      = ((89 + 3 * ANGLE_BITS + 7) / 8) * 8;
  localparam int ROLL_LSB     = 88;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [39:0] CDEG_Q27 = 40'd769010935023;

  // register byte addresses
  localparam logic [3:0] REG_ATT_ID    = 4'h0;
  localparam logic [3:0] REG_ACCEPT_V1 = 4'h4;
  localparam logic [3:0] REG_ACCEPT_V2 = 4'h8;

  typedef enum logic [1:0] {PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CHECK} parse_phase_t;

  typedef struct packed {
    logic                  version;
    logic [7:0]            seq;
    logic [7:0]            sys;
    logic [7:0]            comp;
    logic [23:0]           msg_id;
    logic [7:0]            len;
    logic                  att_valid;
    logic [31:0]           boot_ms;
    logic [ANGLE_BITS-1:0] roll;
    logic [ANGLE_BITS-1:0] pitch;
    logic [ANGLE_BITS-1:0] yaw;
    logic                  clip;
  } frame_report_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata    = 8'h00;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  // seq, sys, comp, msg_id, len, boot_ms, roll, pitch, yaw, clipped, zero fill
  logic [TDATA_W-1:0] out_tdata;
  // frame_version, attitude_valid
  logic [1:0]         out_tuser;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [3:0]         cfg_paddr   = 4'h0;
  logic [31:0]        cfg_pwdata  = 32'h0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  mavlink_frame_attitude_parser_top #(.ANGLE_BITS(ANGLE_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // parser state mirror and register copy
  parse_phase_t p_phase = PH_HUNT;
  logic [7:0]   p_count = 8'd0;
  logic         p_v2    = 1'b0;
  logic [7:0]   p_len   = 8'd0;
  logic [7:0]   p_seq   = 8'd0;
  logic [7:0]   p_sys   = 8'd0;
  logic [7:0]   p_comp  = 8'd0;
  logic [23:0]  p_id    = 24'd0;
  logic [7:0]   p_head [16];
  logic [23:0]  att_id_reg    = ATT_ID_RESET;
  logic         accept_v1_reg = 1'b1;
  logic         accept_v2_reg = 1'b1;

  frame_report_t pending_reports[$];
  int error_count = 0;
  int bytes_sent  = 0;
  int hold_request = 0;
  int rx_stall    = 0;
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** mavlink_frame_attitude_parser_top: FAILED **");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // radians (IEEE single) to centidegrees, truncated, saturated at the angle width
  function automatic logic [ANGLE_BITS-1:0] rad_to_cdeg(input logic [31:0] f, inout bit clip);
    logic [63:0] bound;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [23:0] sig;
    int          sh;
    bound = (64'd1 << (ANGLE_BITS - 1)) - 64'd1;
    if (f[30:23] == 8'hFF) begin
      clip = 1'b1;
      if (f[22:0] != 23'd0) return '0;
      mag = bound;
    end else begin
      sig  = (f[30:23] == 8'h00) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
      sh   = (f[30:23] == 8'h00) ? 176 : 177 - int'(f[30:23]);
      prod = 64'(sig) * 64'(CDEG_Q27);
      if (prod == 64'd0) mag = 64'd0;
      else if (sh <= 0) mag = bound + 64'd1;
      else if (sh >= 64) mag = 64'd0;
      else mag = prod >> sh;
      if (mag > bound) begin
        mag  = bound;
        clip = 1'b1;
      end
    end
    if (f[31]) mag = 64'd0 - mag;
    return mag[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [31:0] head_word(input int at);
    return {p_head[at + 3], p_head[at + 2], p_head[at + 1], p_head[at]};
  endfunction

  // advance the parser mirror by one byte; returns 1 when a frame word is due
  function automatic bit parser_step(input logic [7:0] b, output frame_report_t rep);
    logic [31:0] ts;
    logic [7:0]  last;
    bit          clip;
    rep  = '0;
    clip = 1'b0;
    case (p_phase)
      PH_HUNT: begin
        if ((b == START_V2 && accept_v2_reg) || (b == START_V1 && accept_v1_reg)) begin
          p_v2    = (b == START_V2);
          p_count = 8'd0;
          p_id    = 24'd0;
          foreach (p_head[i]) p_head[i] = 8'h00;
          p_phase = PH_HEADER;
        end
        return 1'b0;
      end
      PH_HEADER: begin
        if (p_v2) begin
          case (p_count)
            HDR_LEN:     p_len = b;
            HDR_V2_SEQ:  p_seq = b;
            HDR_V2_SYS:  p_sys = b;
            HDR_V2_COMP: p_comp = b;
            HDR_V2_ID0:  p_id[7:0] = b;
            HDR_V2_ID1:  p_id[15:8] = b;
            HDR_V2_ID2:  p_id[23:16] = b;
            default: ;
          endcase
          last = HDR_LAST_V2;
        end else begin
          case (p_count)
            HDR_LEN:     p_len = b;
            HDR_V1_SEQ:  p_seq = b;
            HDR_V1_SYS:  p_sys = b;
            HDR_V1_COMP: p_comp = b;
            HDR_V1_ID:   p_id = {16'd0, b};
            default: ;
          endcase
          last = HDR_LAST_V1;
        end
        if (p_count >= last) begin
          p_count = 8'd0;
          p_phase = (p_len != 8'd0) ? PH_PAYLOAD : PH_CHECK;
        end else begin
          p_count = p_count + 8'd1;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        if (p_count < HEAD_DEPTH) p_head[p_count[3:0]] = b;
        p_count = p_count + 8'd1;
        if (p_count >= p_len) begin
          p_count = 8'd0;
          p_phase = PH_CHECK;
        end
        return 1'b0;
      end
      default: begin
        // first checksum byte is skipped, the second closes the frame
        if (p_count == 8'd0) begin
          p_count = 8'd1;
          return 1'b0;
        end
        ts = head_word(0);
        rep.version   = p_v2;
        rep.seq       = p_seq;
        rep.sys       = p_sys;
        rep.comp      = p_comp;
        rep.msg_id    = p_id;
        rep.len       = p_len;
        rep.att_valid = (p_id == att_id_reg) && (ts != 32'd0);
        if (rep.att_valid) begin
          rep.boot_ms = ts;
          rep.roll    = rad_to_cdeg(head_word(4), clip);
          rep.pitch   = rad_to_cdeg(head_word(8), clip);
          rep.yaw     = rad_to_cdeg(head_word(12), clip);
          rep.clip    = clip;
        end
        p_phase = PH_HUNT;
        p_count = 8'd0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic check_report();
    frame_report_t want;
    frame_report_t got;
    got.version   = out_tuser[0];
    got.att_valid = out_tuser[1];
    got.seq       = out_tdata[7:0];
    got.sys       = out_tdata[15:8];
    got.comp      = out_tdata[23:16];
    got.msg_id    = out_tdata[47:24];
    got.len       = out_tdata[55:48];
    got.boot_ms   = out_tdata[87:56];
    got.roll      = out_tdata[ROLL_LSB +: ANGLE_BITS];
    got.pitch     = out_tdata[ROLL_LSB + ANGLE_BITS +: ANGLE_BITS];
    got.yaw       = out_tdata[ROLL_LSB + 2 * ANGLE_BITS +: ANGLE_BITS];
    got.clip      = out_tdata[ROLL_LSB + 3 * ANGLE_BITS];
    if (pending_reports.size() == 0) begin
      $error("result word with no frame pending: 0x%0h", out_tdata);
      error_count++;
      return;
    end
    want = pending_reports.pop_front();
    check_field("frame_version", want.version, got.version);
    check_field("seq_num", want.seq, got.seq);
    check_field("system_id", want.sys, got.sys);
    check_field("component_id", want.comp, got.comp);
    check_field("msg_id", want.msg_id, got.msg_id);
    check_field("payload_length", want.len, got.len);
    check_field("attitude_valid", want.att_valid, got.att_valid);
    check_field("boot_time_ms", want.boot_ms, got.boot_ms);
    check_field("roll_cdeg", want.roll, got.roll);
    check_field("pitch_cdeg", want.pitch, got.pitch);
    check_field("yaw_cdeg", want.yaw, got.yaw);
    check_field("angle_clipped", want.clip, got.clip);
  endtask

  // result side: check each word, then pick the next ready value
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_report();
    if (hold_request > 0) begin
      rx_stall     = hold_request;
      hold_request = 0;
    end else if (rx_stall == 0 && rx_idle_on && $urandom_range(0, 99) < 20) begin
      rx_stall = pick_gap();
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // offer one byte, wait for it to be taken, then update the mirror
  task automatic send_byte(input logic [7:0] b);
    frame_report_t rep;
    int            gap;
    if (tx_idle_on && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    if (parser_step(b, rep)) pending_reports.push_back(rep);
  endtask

  // one frame; payload starts with timestamp and three angles, cut < 0 keeps it whole
  task automatic send_frame(input bit v2, input logic [7:0] len, input logic [23:0] id,
                            input logic [31:0] ts, input logic [31:0] roll_f,
                            input logic [31:0] pitch_f, input logic [31:0] yaw_f,
                            input int cut = -1);
    logic [7:0]   frame_bytes[$];
    logic [127:0] head;
    head = {yaw_f, pitch_f, roll_f, ts};
    if (v2) begin
      frame_bytes = {START_V2, len, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), id[7:0], id[15:8], id[23:16]};
    end else begin
      frame_bytes = {START_V1, len, 8'($urandom), 8'($urandom), 8'($urandom), id[7:0]};
    end
    for (int i = 0; i < int'(len); i++)
      frame_bytes.push_back((i < 16) ? head[8 * i +: 8] : 8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    if (cut >= 0)
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  function automatic logic [31:0] rand_angle();
    logic        s;
    logic [22:0] fr;
    s  = 1'($urandom);
    fr = 23'($urandom);
    case ($urandom_range(0, 11))
      0: return {s, 31'd0};
      1: return {s, 8'hFF, 23'd0};
      2: return {s, 8'hFF, (fr == 23'd0) ? 23'd1 : fr};
      3: return {s, 8'h00, fr};
      4: return {s, 8'($urandom_range(136, 139)), fr};
      5: return {s, 8'($urandom_range(140, 254)), fr};
      6: return $urandom;
      default: return {s, 8'($urandom_range(100, 135)), fr};
    endcase
  endfunction

  function automatic logic [7:0] rand_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 8'd28;
    if (pick < 70) return 8'($urandom_range(16, 40));
    if (pick < 95) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(41, 255));
  endfunction

  // stop offering and wait for every pending word, with a guard
  task automatic wait_all_reports();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_reports.size() != 0) begin
      $error("%0d result words never arrived", pending_reports.size());
      error_count++;
      pending_reports.delete();
    end
  endtask

  task automatic cfg_access(input logic wr, input logic [3:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    cfg_access(1'b0, REG_ATT_ID, 32'd0, rd);
    check_field("attitude_msg_id readback", {8'd0, att_id_reg}, rd);
    cfg_access(1'b0, REG_ACCEPT_V1, 32'd0, rd);
    check_field("accept_v1 readback", {31'd0, accept_v1_reg}, rd);
    cfg_access(1'b0, REG_ACCEPT_V2, 32'd0, rd);
    check_field("accept_v2 readback", {31'd0, accept_v2_reg}, rd);
  endtask

  // bring the parser back to hunting, let it go quiet, then reprogram
  task automatic apply_settings(input logic [23:0] id, input logic v1, input logic v2);
    logic [31:0] rd;
    while (p_phase != PH_HUNT) send_byte(8'h00);
    wait_all_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_access(1'b1, REG_ATT_ID, {8'd0, id}, rd);
    att_id_reg = id;
    cfg_access(1'b1, REG_ACCEPT_V1, {31'd0, v1}, rd);
    accept_v1_reg = v1;
    cfg_access(1'b1, REG_ACCEPT_V2, {31'd0, v2}, rd);
    accept_v2_reg = v2;
    check_registers();
  endtask

  task automatic test_register_reset();
    check_registers();
  endtask

  task automatic test_directed_frames();
    // stray bytes while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7E);
    send_byte(8'h55);
    // zero-length v1 frame: straight to checksum, no timestamp
    send_frame(1'b0, 8'd0, 24'd30, 32'd0, 32'd0, 32'd0, 32'd0);
    // ordinary attitude: 0.5, -1.0, pi
    send_frame(1'b1, 8'd28, 24'd30, 32'd1, 32'h3F000000, 32'hBF800000, 32'h40490FDB);
    // infinities and NaN
    send_frame(1'b1, 8'd28, 24'd30, 32'hFFFFFFFF, 32'h7F800000, 32'hFF800000, 32'h7FC00001);
    // negative zero, largest denormal, largest finite
    send_frame(1'b1, 8'd28, 24'd30, 32'd1234, 32'h80000000, 32'h007FFFFF, 32'h7F7FFFFF);
    // most negative finite, just under and just over the bound
    send_frame(1'b1, 8'd28, 24'd30, 32'd5, 32'hFF7FFFFF, 32'h44B70000, 32'hC4B80000);
    // attitude id with zero timestamp is not decoded
    send_frame(1'b1, 8'd28, 24'd30, 32'd0, 32'h3F800000, 32'h3F800000, 32'h3F800000);
    // short payload: missing bytes read as zero
    send_frame(1'b1, 8'd6, 24'd30, 32'h00000100, 32'h4049FFFF, 32'h3F800000, 32'h3F800000);
    // long payload: bytes past the sixteenth are not kept
    send_frame(1'b1, 8'd40, 24'd30, 32'hDEADBEEF, 32'hBF000000, 32'h42C80000, 32'h00000001);
    // v1 attitude frame
    send_frame(1'b0, 8'd28, 24'd30, 32'h80000000, 32'h3DCCCCCD, 32'hBDCCCCCD, 32'h40000000);
    // top id, longest payload
    send_frame(1'b1, 8'd255, 24'hFFFFFF, 32'd7, 32'd0, 32'd0, 32'd0);
    // truncated v2 header, then a v1 frame
    send_frame(1'b1, 8'd28, 24'd30, 32'd9, 32'd0, 32'd0, 32'd0, 5);
    send_frame(1'b0, 8'd3, 24'd30, 32'd9, 32'd0, 32'd0, 32'd0);
    wait_all_reports();
  endtask

  task automatic test_config_sweep();
    logic [23:0] id;
    apply_settings(24'hFFFFFF, 1'b1, 1'b1);
    repeat (3) send_frame(1'b1, 8'd28, 24'hFFFFFF, $urandom | 32'd1, rand_angle(),
                          rand_angle(), rand_angle());
    send_frame(1'b0, 8'd28, 24'hFFFFFF, 32'd3, rand_angle(), rand_angle(), rand_angle());
    // v1 off: 0xFE start bytes are ignored
    apply_settings(24'd0, 1'b0, 1'b1);
    send_frame(1'b0, 8'd12, 24'd0, 32'd1, rand_angle(), rand_angle(), rand_angle());
    repeat (3) send_frame(1'b1, 8'd28, 24'd0, $urandom | 32'd1, rand_angle(),
                          rand_angle(), rand_angle());
    // v2 off
    id = 24'($urandom_range(1, 255));
    apply_settings(id, 1'b1, 1'b0);
    send_frame(1'b1, 8'd12, id, 32'd1, rand_angle(), rand_angle(), rand_angle());
    repeat (3) send_frame(1'b0, 8'd28, id, $urandom | 32'd1, rand_angle(),
                          rand_angle(), rand_angle());
    // both off: nothing starts
    apply_settings(24'($urandom), 1'b0, 1'b0);
    send_frame(1'b0, 8'd4, 24'd0, 32'd1, 32'd0, 32'd0, 32'd0);
    send_frame(1'b1, 8'd4, 24'd0, 32'd1, 32'd0, 32'd0, 32'd0);
    repeat (10) send_byte($urandom_range(0, 1) ? START_V1 : START_V2);
  endtask

  task automatic test_random_traffic();
    int          first;
    int          kind;
    bit          v2;
    logic [23:0] id;
    logic [31:0] ts;
    apply_settings(24'($urandom_range(0, 255)), 1'b1, 1'b1);
    first = bytes_sent;
    while (bytes_sent - first < 170) begin
      if ($urandom_range(0, 99) < 3) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 99) < 3) rx_idle_on = !rx_idle_on;
      kind = $urandom_range(0, 99);
      v2   = 1'($urandom);
      if ($urandom_range(0, 9) < 7) id = att_id_reg;
      else id = v2 ? 24'($urandom) : 24'($urandom_range(0, 255));
      ts = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      if (kind < 10) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end else if (kind < 20) begin
        send_frame(v2, rand_len(), id, ts, rand_angle(), rand_angle(), rand_angle(),
                   $urandom_range(1, 14));
      end else begin
        send_frame(v2, rand_len(), id, ts, rand_angle(), rand_angle(), rand_angle());
      end
      // sender pause until all frames are through
      if ($urandom_range(0, 99) < 4) wait_all_reports();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off while frames keep coming, so the queue fills and input stalls
  task automatic test_backpressure();
    tx_idle_on   = 1'b0;
    hold_request = 400;
    repeat (6) begin
      send_frame(1'b0, 8'd0, 24'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_frame(1'b1, 8'd16, att_id_reg, 32'd77, rand_angle(), rand_angle(), rand_angle());
    end
    wait_all_reports();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed_frames();
    test_config_sweep();
    test_random_traffic();
    test_backpressure();
    wait_all_reports();
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (error_count == 0) begin
      $display("** mavlink_frame_attitude_parser_top: PASSED **");
    end else begin
      $display("** mavlink_frame_attitude_parser_top: FAILED **");
    end
    $finish;
  end

endmodule

/* mavlink_frame_attitude_parser_top.f */
rtl/mfap_pkg.sv
rtl/mfap_parser.sv
rtl/mfap_angle_cvt.sv
rtl/mfap_out_queue.sv
rtl/mavlink_frame_attitude_parser_top.sv
tb/sv/testbench.sv
